>>> hdl/counting_sort_by_depth_desc_top_macros.svh
// assertion macros for the descending depth counting sort block
// used by the port checker; no other dependencies
`ifndef COUNTING_SORT_BY_DEPTH_DESC_TOP_MACROS_SVH
`define COUNTING_SORT_BY_DEPTH_DESC_TOP_MACROS_SVH

// clocked check, switched off while reset is high
`define CSBD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define CSBD_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/csbd_pkg.sv
// shared codes and field widths for the descending depth counting sort block
// no dependencies
package csbd_pkg;

  localparam int KEY_W  = 10;
  localparam int POS_W  = 10;
  localparam int IDX_W  = 10;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 11;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DEEP     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_UNSORTED = 3'd4;

  localparam logic [CFG_W-1:0] MAX_DEPTH_RESET = 11'd1024;

endpackage

>>> hdl/counting_sort_by_depth_desc_top.sv
// descending counting sort of node depth keys, top level
// depends on csbd_pkg and csbd_ram
//
// usage: items arrive on the s_ stream; s_tuser is the command (load or read),
// s_tlast marks the final key of a set. a load stores the key under the next
// node index (its arrival order) and returns that index, the key and a status.
// after the load marked last the block sorts: a clearing pass over all
// DEPTH_BINS histogram bins, a count pass, a suffix sum over the active bins,
// and a placement pass. reads then return node index and depth at a sorted
// rank, deepest first; equal depths come out in descending index order.
// every accepted item gives exactly one result transfer on the m_ stream.
// a load result is shown the cycle after its transfer; a read result goes
// through the order and key memory reads first. loads can follow every cycle
// while results are taken; a read holds off new items until its result is in
// the output register. the sort after a last load is paced by read-modify-write
// on the one bin memory port; s_tready is low during it.
// a new item is taken while the output register is empty or being drained; a
// stalled result holds there with s_tready low until taken. reset clears the
// control state, count and sorted flag and loads max_depth with 1024; the
// memories are not cleared at reset.
module counting_sort_by_depth_desc_top #(
  parameter int MAX_NODES  = 1024,
  parameter int DEPTH_BINS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: max_depth
  input  logic                        cfg_wr_en,
  input  logic [csbd_pkg::CFG_W-1:0]  cfg_wr_data,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,  // key_depth[9:0], read_position[19:10], zero pad
  input  logic                        s_tuser,  // cmd
  input  logic                        s_tlast,  // load_last
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,  // node_index[9:0], node_depth[19:10], zero pad
  output logic [csbd_pkg::STAT_W-1:0] m_tuser   // status
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int BIN_W  = (DEPTH_BINS > 1) ? $clog2(DEPTH_BINS) : 1;
  localparam int LIM_W  = $clog2(DEPTH_BINS + 1);

  // one-hot sequencer states
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CLEAR  = 13'b0000000000010,
    S_CNT_KEY = 13'b0000000000100,
    S_CNT_BIN = 13'b0000000001000,
    S_CNT_WR = 13'b0000000010000,
    S_SUF_RD = 13'b0000000100000,
    S_SUF_WR = 13'b0000001000000,
    S_PL_KEY = 13'b0000010000000,
    S_PL_BIN = 13'b0000100000000,
    S_PL_WR  = 13'b0001000000000,
    S_RD_ORD = 13'b0010000000000,
    S_RD_KEY = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  // control registers
  state_t                       state, state_next;
  logic [csbd_pkg::CFG_W-1:0]   max_depth;
  logic [CNT_W-1:0]             loaded_count, loaded_count_next;
  logic                         sort_done, sort_done_next;
  logic                         out_valid, out_valid_next;

  // datapath registers
  logic [NODE_W-1:0]            idx, idx_next;          // node walk, or node index of a read
  logic [BIN_W-1:0]             bin_ptr, bin_ptr_next;  // bin walk
  logic [BIN_W-1:0]             bin_sel, bin_sel_next;  // bin of the current node
  logic [CNT_W-1:0]             acc, acc_next;          // running suffix sum
  logic [csbd_pkg::IDX_W-1:0]   out_index, out_index_next;
  logic [csbd_pkg::KEY_W-1:0]   out_depth, out_depth_next;
  logic [csbd_pkg::STAT_W-1:0]  out_status, out_status_next;

  // input fields
  logic [csbd_pkg::KEY_W-1:0]   in_key;
  logic [csbd_pkg::POS_W-1:0]   in_pos;
  logic                         in_xfer;

  // derived values
  logic [LIM_W-1:0]             limit;
  logic [CNT_W-1:0]             cnt_eff;
  logic                         key_deep;
  logic                         store_full;
  logic                         last_node;
  logic                         last_clear;

  // memory ports
  logic                         key_we;
  logic [NODE_W-1:0]            key_waddr;
  logic [NODE_W-1:0]            key_raddr;
  logic [csbd_pkg::KEY_W-1:0]   key_rdata;
  logic                         bin_we;
  logic [BIN_W-1:0]             bin_waddr;
  logic [CNT_W-1:0]             bin_wdata;
  logic [BIN_W-1:0]             bin_raddr;
  logic [CNT_W-1:0]             bin_rdata;
  logic                         ord_we;
  logic [NODE_W-1:0]            ord_waddr;
  logic [NODE_W-1:0]            ord_raddr;
  logic [NODE_W-1:0]            ord_rdata;

  assign in_key  = s_tdata[9:0];
  assign in_pos  = s_tdata[19:10];
  assign s_tready = (state == S_IDLE) && (!out_valid || m_tready);
  assign in_xfer = s_tvalid && s_tready;

  // effective depth limit: min(max_depth, DEPTH_BINS)
  assign limit = (32'(max_depth) < DEPTH_BINS) ? LIM_W'(max_depth) : LIM_W'(DEPTH_BINS);

  // a load after a finished sort starts a new set
  assign cnt_eff    = sort_done ? '0 : loaded_count;
  assign key_deep   = 32'(in_key) >= 32'(limit);
  assign store_full = cnt_eff >= CNT_W'(MAX_NODES);
  assign last_node  = (CNT_W'(idx) + CNT_W'(1)) == loaded_count;
  assign last_clear = bin_ptr == BIN_W'(DEPTH_BINS - 1);

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_depth, out_index};
  assign m_tuser  = out_status;

  always_comb begin
    state_next        = state;
    loaded_count_next = loaded_count;
    sort_done_next    = sort_done;
    out_valid_next    = out_valid && !m_tready;
    idx_next          = idx;
    bin_ptr_next      = bin_ptr;
    bin_sel_next      = bin_sel;
    acc_next          = acc;
    out_index_next    = out_index;
    out_depth_next    = out_depth;
    out_status_next   = out_status;

    key_we    = 1'b0;
    key_waddr = NODE_W'(cnt_eff);
    key_raddr = idx;
    bin_we    = 1'b0;
    bin_waddr = bin_ptr;
    bin_wdata = '0;
    bin_raddr = bin_ptr;
    ord_we    = 1'b0;
    ord_waddr = NODE_W'(bin_rdata - CNT_W'(1));
    ord_raddr = NODE_W'(in_pos);

    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (s_tuser == csbd_pkg::CMD_LOAD) begin
            sort_done_next  = 1'b0;
            out_valid_next  = 1'b1;
            out_depth_next  = in_key;
            out_index_next  = '0;
            loaded_count_next = cnt_eff;
            if (key_deep) begin
              out_status_next = csbd_pkg::STAT_DEEP;
            end else if (store_full) begin
              out_status_next = csbd_pkg::STAT_FULL;
            end else begin
              out_status_next   = csbd_pkg::STAT_OK;
              out_index_next    = csbd_pkg::IDX_W'(cnt_eff);
              key_we            = 1'b1;
              loaded_count_next = cnt_eff + CNT_W'(1);
            end
            if (s_tlast) begin
              bin_ptr_next = '0;
              state_next   = S_CLEAR;
            end
          end else begin
            out_index_next = '0;
            out_depth_next = '0;
            if (!sort_done) begin
              out_valid_next  = 1'b1;
              out_status_next = csbd_pkg::STAT_UNSORTED;
            end else if (32'(in_pos) >= 32'(loaded_count)) begin
              out_valid_next  = 1'b1;
              out_status_next = csbd_pkg::STAT_RANGE;
            end else begin
              // order memory is addressed by the rank this cycle
              state_next = S_RD_ORD;
            end
          end
        end
      end

      // clearing pass over every bin
      S_CLEAR: begin
        bin_we       = 1'b1;
        bin_wdata    = '0;
        bin_ptr_next = bin_ptr + BIN_W'(1);
        if (last_clear) begin
          idx_next     = '0;
          acc_next     = '0;
          bin_ptr_next = BIN_W'(limit - LIM_W'(1));
          if (loaded_count != '0) begin
            state_next = S_CNT_KEY;
          end else if (limit != '0) begin
            state_next = S_SUF_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      // histogram fill: key read, bin read, bin write
      S_CNT_KEY: begin
        key_raddr  = idx;
        state_next = S_CNT_BIN;
      end

      S_CNT_BIN: begin
        bin_raddr    = BIN_W'(key_rdata);
        bin_sel_next = BIN_W'(key_rdata);
        state_next   = S_CNT_WR;
      end

      S_CNT_WR: begin
        bin_we    = 1'b1;
        bin_waddr = bin_sel;
        bin_wdata = bin_rdata + CNT_W'(1);
        idx_next  = idx + NODE_W'(1);
        if (!last_node) begin
          state_next = S_CNT_KEY;
        end else if (limit != '0) begin
          state_next = S_SUF_RD;
        end else begin
          idx_next   = '0;
          state_next = S_PL_KEY;
        end
      end

      // suffix sum from the top active bin down to bin zero
      S_SUF_RD: begin
        bin_raddr  = bin_ptr;
        state_next = S_SUF_WR;
      end

      S_SUF_WR: begin
        bin_we    = 1'b1;
        bin_waddr = bin_ptr;
        bin_wdata = acc + bin_rdata;
        acc_next  = acc + bin_rdata;
        if (bin_ptr != '0) begin
          bin_ptr_next = bin_ptr - BIN_W'(1);
          state_next   = S_SUF_RD;
        end else if (loaded_count != '0) begin
          idx_next   = '0;
          state_next = S_PL_KEY;
        end else begin
          state_next = S_DONE;
        end
      end

      // placement: key read, bin read, order and bin write
      S_PL_KEY: begin
        key_raddr  = idx;
        state_next = S_PL_BIN;
      end

      S_PL_BIN: begin
        bin_raddr    = BIN_W'(key_rdata);
        bin_sel_next = BIN_W'(key_rdata);
        state_next   = S_PL_WR;
      end

      S_PL_WR: begin
        if (bin_rdata != '0) begin
          ord_we    = 1'b1;
          ord_waddr = NODE_W'(bin_rdata - CNT_W'(1));
          bin_we    = 1'b1;
          bin_waddr = bin_sel;
          bin_wdata = bin_rdata - CNT_W'(1);
        end
        idx_next = idx + NODE_W'(1);
        if (last_node) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PL_KEY;
        end
      end

      S_DONE: begin
        sort_done_next = 1'b1;
        state_next     = S_IDLE;
      end

      // read: order data is back, fetch its key
      S_RD_ORD: begin
        idx_next   = ord_rdata;
        key_raddr  = ord_rdata;
        state_next = S_RD_KEY;
      end

      S_RD_KEY: begin
        out_valid_next  = 1'b1;
        out_index_next  = csbd_pkg::IDX_W'(idx);
        out_depth_next  = key_rdata;
        out_status_next = csbd_pkg::STAT_OK;
        state_next      = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_depth    <= csbd_pkg::MAX_DEPTH_RESET;
      loaded_count <= '0;
      sort_done    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      loaded_count <= loaded_count_next;
      sort_done    <= sort_done_next;
      out_valid    <= out_valid_next;
      if (cfg_wr_en) begin
        max_depth <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    bin_ptr    <= bin_ptr_next;
    bin_sel    <= bin_sel_next;
    acc        <= acc_next;
    out_index  <= out_index_next;
    out_depth  <= out_depth_next;
    out_status <= out_status_next;
  end

  // key store: written by loads, read by the sort passes and by reads
  csbd_ram #(
    .WIDTH (csbd_pkg::KEY_W),
    .DEPTH (MAX_NODES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_waddr),
    .wr_data (in_key),
    .rd_addr (key_raddr),
    .rd_data (key_rdata)
  );

  // depth histogram, later the suffix sums
  csbd_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH_BINS)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (bin_we),
    .wr_addr (bin_waddr),
    .wr_data (bin_wdata),
    .rd_addr (bin_raddr),
    .rd_data (bin_rdata)
  );

  // sorted order: rank to node index
  csbd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_ord_ram (
    .clk     (clk),
    .wr_en   (ord_we),
    .wr_addr (ord_waddr),
    .wr_data (idx),
    .rd_addr (ord_raddr),
    .rd_data (ord_rdata)
  );

endmodule

>>> hdl/csbd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module csbd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/csbd_checker.sv
// port-level checks for the descending depth counting sort top level
// depends on csbd_pkg and counting_sort_by_depth_desc_top_macros.svh; bound below
`include "counting_sort_by_depth_desc_top_macros.svh"

module csbd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        s_tuser,
  input logic                        s_tlast,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [23:0]                 m_tdata,
  input logic [csbd_pkg::STAT_W-1:0] m_tuser
);

  logic load_xfer;
  logic out_stall;
  logic fail_out;
  logic [23+csbd_pkg::STAT_W:0] m_word;

  assign load_xfer = s_tvalid && s_tready && (s_tuser == csbd_pkg::CMD_LOAD);
  assign out_stall = m_tvalid && !m_tready;
  assign fail_out  = m_tvalid && (m_tuser != csbd_pkg::STAT_OK);
  assign m_word    = {m_tdata, m_tuser};

  // no result is pending after reset
  `CSBD_ASSERT_NR(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  // a stalled result holds
  `CSBD_ASSERT(a_hold, clk, rst, out_stall |=> m_tvalid && $stable(m_word), "stalled result changed")

  // every load gives its result in the next cycle
  `CSBD_ASSERT(a_load_result, clk, rst, load_xfer |=> m_tvalid, "load result missing")

  // the last load starts the sort, so no item is taken right after it
  `CSBD_ASSERT(a_sort_busy, clk, rst, load_xfer && s_tlast |=> !s_tready, "ready during sort")

  // a failed item reports node index zero
  `CSBD_ASSERT(a_fail_index, clk, rst, fail_out |-> m_tdata[9:0] == '0, "nonzero index on failure")

endmodule

bind counting_sort_by_depth_desc_top csbd_checker u_csbd_checker (.*);
